[rtl/core/tfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_pkg: tracker frame deframer shared definitions
// Frame constants, phase and verdict codes, and the beat payload types.
// ----------------------------------------------------------------------------
package tfd_pkg;

   localparam int MaxFrame      = 2048;
   localparam int CountWidth    = $clog2(MaxFrame);
   localparam int FrameOverhead = 5;
   localparam int SerialLen     = 4;
   localparam int HdrLast       = 8;

   localparam logic [7:0] StartByte = 8'h29;
   localparam logic [7:0] EndByte   = 8'h0D;

   typedef enum logic [1:0] {
      PhHunt   = 2'd0,
      PhStart2 = 2'd1,
      PhHeader = 2'd2,
      PhBody   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      StatNone     = 3'd0,
      StatGood     = 3'd1,
      StatBadStart = 3'd2,
      StatBadEnd   = 3'd3,
      StatBadSum   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_kept;
      logic [10:0] byte_index;
      logic        frame_last;
      status_type  frame_status;
      logic        too_long;
      logic [7:0]  message_id;
      logic [31:0] serial_number;
      logic [15:0] length_value;
   } rsp_type;

endpackage : tfd_pkg
`default_nettype wire

[rtl/core/tfd_channels.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfd channels: valid/ready beat interfaces
// Request channel carries received bytes, response channel carries results.
// ----------------------------------------------------------------------------
interface tfd_req_if;
   logic             valid;
   logic             ready;
   tfd_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : tfd_req_if

interface tfd_rsp_if;
   logic             valid;
   logic             ready;
   tfd_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : tfd_rsp_if
`default_nettype wire

[rtl/core/tfd_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_step: per-byte frame state and result logic
// Holds the hunt/header/body phase, byte count, header fields and lagged
// checksum; forms the result for the current byte and advances on a beat.
// ----------------------------------------------------------------------------
module tfd_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [7:0]       rx_byte,
   output tfd_pkg::rsp_type      result
);

   localparam int SumWidth  = 18;
   localparam int BodyWidth = 17;

   tfd_pkg::phase_type phase_ff, phase_in;
   logic [tfd_pkg::CountWidth-1:0] count_ff, count_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] serial_ff, serial_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  prev2_ff, prev2_in;

   logic [7:0] lagged_sum;
   logic       is_start;
   logic       hdr_end;
   logic       len_over;
   logic       len_short;
   logic       body_end;
   logic [tfd_pkg::CountWidth-1:0] count_inc;

   assign lagged_sum = xor_ff ^ prev2_ff;
   assign is_start   = (rx_byte == tfd_pkg::StartByte);
   assign hdr_end    = (count_ff >= tfd_pkg::CountWidth'(tfd_pkg::HdrLast));
   assign len_over   = (SumWidth'(tfd_pkg::FrameOverhead) + SumWidth'(len_ff))
                       > SumWidth'(tfd_pkg::MaxFrame);
   assign len_short  = (len_ff <= 16'(tfd_pkg::SerialLen));
   assign body_end   = (BodyWidth'(count_ff)
                        >= (BodyWidth'(tfd_pkg::SerialLen) + BodyWidth'(len_ff)));
   assign count_inc  = count_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         tfd_pkg::PhHunt: begin
            if (is_start) phase_in = tfd_pkg::PhStart2;
         end
         tfd_pkg::PhStart2: begin
            phase_in = is_start ? tfd_pkg::PhHeader : tfd_pkg::PhHunt;
         end
         tfd_pkg::PhHeader: begin
            if (hdr_end) begin
               phase_in = (len_over || len_short) ? tfd_pkg::PhHunt : tfd_pkg::PhBody;
            end
         end
         tfd_pkg::PhBody: begin
            if (body_end) phase_in = tfd_pkg::PhHunt;
         end
         default: phase_in = tfd_pkg::PhHunt;
      endcase
   end

   // datapath and result
   always_comb begin
      count_in  = count_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      serial_in = serial_ff;
      xor_in    = xor_ff;
      prev_in   = prev_ff;
      prev2_in  = prev2_ff;
      result               = '0;
      result.out_byte      = rx_byte;
      result.frame_status  = tfd_pkg::StatNone;

      unique case (phase_ff)
         tfd_pkg::PhHunt: begin
            if (is_start) begin
               result.byte_kept = 1'b1;
               xor_in   = 8'h00;
               prev2_in = 8'h00;
               prev_in  = rx_byte;
               count_in = tfd_pkg::CountWidth'(1);
            end
         end
         tfd_pkg::PhStart2: begin
            result.byte_kept  = 1'b1;
            result.byte_index = 11'd1;
            if (!is_start) begin
               result.frame_last   = 1'b1;
               result.frame_status = tfd_pkg::StatBadStart;
            end else begin
               xor_in   = lagged_sum;
               prev2_in = prev_ff;
               prev_in  = rx_byte;
               count_in = tfd_pkg::CountWidth'(2);
            end
         end
         tfd_pkg::PhHeader: begin
            result.byte_kept  = 1'b1;
            result.byte_index = 11'(count_ff);
            if (count_ff == tfd_pkg::CountWidth'(2)) begin
               id_in = rx_byte;
            end else if (count_ff == tfd_pkg::CountWidth'(3)
                         || count_ff == tfd_pkg::CountWidth'(4)) begin
               len_in = {len_ff[7:0], rx_byte};
            end else begin
               serial_in = {serial_ff[23:0], rx_byte};
            end
            if (hdr_end && (len_over || len_short)) begin
               result.frame_last    = 1'b1;
               result.message_id    = id_in;
               result.serial_number = serial_in;
               result.length_value  = len_in;
               if (len_over) begin
                  result.too_long = 1'b1;
               end else if (rx_byte != tfd_pkg::EndByte) begin
                  result.frame_status = tfd_pkg::StatBadEnd;
               end else if (lagged_sum != prev_ff) begin
                  result.frame_status = tfd_pkg::StatBadSum;
               end else begin
                  result.frame_status = tfd_pkg::StatGood;
               end
            end else begin
               xor_in   = lagged_sum;
               prev2_in = prev_ff;
               prev_in  = rx_byte;
               count_in = count_inc;
            end
         end
         tfd_pkg::PhBody: begin
            result.byte_kept  = 1'b1;
            result.byte_index = 11'(count_ff);
            if (body_end) begin
               result.frame_last    = 1'b1;
               result.message_id    = id_ff;
               result.serial_number = serial_ff;
               result.length_value  = len_ff;
               if (rx_byte != tfd_pkg::EndByte) begin
                  result.frame_status = tfd_pkg::StatBadEnd;
               end else if (lagged_sum != prev_ff) begin
                  result.frame_status = tfd_pkg::StatBadSum;
               end else begin
                  result.frame_status = tfd_pkg::StatGood;
               end
            end else begin
               xor_in   = lagged_sum;
               prev2_in = prev_ff;
               prev_in  = rx_byte;
               count_in = count_inc;
            end
         end
         default: begin
            result.byte_kept = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tfd_pkg::PhHunt;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         id_ff     <= id_in;
         len_ff    <= len_in;
         serial_ff <= serial_in;
         xor_ff    <= xor_in;
         prev_ff   <= prev_in;
         prev2_ff  <= prev2_in;
      end
   end

endmodule : tfd_step
`default_nettype wire

[rtl/core/tfd_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_out_reg: result register
// Holds one result beat; refills in the same cycle the held beat is taken.
// ----------------------------------------------------------------------------
module tfd_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire tfd_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output tfd_pkg::rsp_type      out_data
);

   logic             valid_ff, valid_in;
   tfd_pkg::rsp_type data_ff;

   assign in_ready  = !reset && (!valid_ff || out_ready);
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule : tfd_out_reg
`default_nettype wire

[rtl/core/tracker_frame_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tracker_frame_deframer_unit: length-prefixed frame deframer
// Hunts for the double start byte, captures the header, counts the frame
// out and reports end-byte and XOR checksum verdicts, one result per byte.
//
//   channel  dir  beat contents
//   req_beat in   rx_byte
//   rsp_beat out  out_byte, byte_kept, byte_index, frame_last, frame_status,
//                 too_long, message_id, serial_number, length_value
//
// One byte per cycle while results drain; each result is registered and appears
// in the cycle after its byte is taken. Throughput is set by the single result
// register, refilled as it drains. Reset clears the phase and the result register;
// ready is low while reset is high.
// A stalled result holds req_beat.ready low until the result is taken.
// ----------------------------------------------------------------------------
module tracker_frame_deframer_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   tfd_req_if.sink    req_beat,
   tfd_rsp_if.source  rsp_beat
);

   logic             step_advance;
   logic             out_ready;
   tfd_pkg::rsp_type step_result;

   assign step_advance   = req_beat.valid && out_ready;
   assign req_beat.ready = out_ready;

   tfd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (step_advance),
      .rx_byte (req_beat.data.rx_byte),
      .result  (step_result)
   );

   tfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_beat.valid),
      .in_ready  (out_ready),
      .in_data   (step_result),
      .out_valid (rsp_beat.valid),
      .out_ready (rsp_beat.ready),
      .out_data  (rsp_beat.data)
   );

endmodule : tracker_frame_deframer_unit
`default_nettype wire

[rtl/core/tfd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_checker: port-level checks for the deframer
// Watches the request and response beats of the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire tfd_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire tfd_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_byte_passes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=>
         rsp_valid && rsp_data.out_byte == $past(req_data.rx_byte))
      else $error("accepted byte did not reach the response");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.frame_status != tfd_pkg::StatNone || rsp_data.too_long)
         |-> rsp_data.frame_last && rsp_data.byte_kept)
      else $error("verdict on a byte that does not end a frame");

   a_unkept_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_kept
         |-> rsp_data.byte_index == 11'd0 && !rsp_data.frame_last)
      else $error("byte outside a frame carries frame fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule : tfd_checker

bind tracker_frame_deframer_unit tfd_checker u_tfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_beat.valid),
   .req_ready (req_beat.ready),
   .req_data  (req_beat.data),
   .rsp_valid (rsp_beat.valid),
   .rsp_ready (rsp_beat.ready),
   .rsp_data  (rsp_beat.data)
);
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: tracker frame deframer unit
// Drives a received byte stream into the deframer and checks every result
// beat against a byte-level model of the frame parser. The stream is built
// from whole frames with random headers and bodies, some faulted: bad start,
// bad end byte, bad checksum, oversize length or a cut-off frame. Noise sits
// between the frames. The run first sends a few fixed cases, then three
// random phases with different idle rates on each side. Between the second
// and third phase the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import tfd_pkg::*;

   typedef enum {FaultNone, FaultEnd, FaultSum, FaultBoth, FaultCut} fault_type;

   class deframe_scoreboard;
      phase_type   ph;
      int          frame_pos;
      logic [7:0]  msg_id;
      logic [15:0] len_field;
      logic [31:0] serial;
      logic [7:0]  xor_acc;
      logic [7:0]  last1;
      logic [7:0]  last2;
      rsp_type     pending_results[$];
      int          errors;
      int          results_seen;
      int          top_index;
      int          verdicts[5];
      int          oversize;

      function new();
         ph        = PhHunt;
         frame_pos = 0;
         msg_id    = '0;
         len_field = '0;
         serial    = '0;
         xor_acc   = '0;
         last1     = '0;
         last2     = '0;
      endfunction

      function void shift_in(logic [7:0] b);
         xor_acc = xor_acc ^ last2;
         last2   = last1;
         last1   = b;
      endfunction

      function void fill_header(inout rsp_type e);
         e.message_id    = msg_id;
         e.serial_number = serial;
         e.length_value  = len_field;
      endfunction

      function void close_frame(logic [7:0] b, inout rsp_type e);
         logic [7:0] sum;
         sum = xor_acc ^ last2;
         e.frame_last = 1'b1;
         if (b != EndByte) begin
            e.frame_status = StatBadEnd;
         end else if (sum != last1) begin
            e.frame_status = StatBadSum;
         end else begin
            e.frame_status = StatGood;
         end
         fill_header(e);
         ph = PhHunt;
      endfunction

      function void note_byte(logic [7:0] b);
         rsp_type e;
         int      idx;
         e = '0;
         e.out_byte = b;
         e.frame_status = StatNone;
         case (ph)
            PhHunt: begin
               if (b == StartByte) begin
                  e.byte_kept = 1'b1;
                  xor_acc = '0;
                  last1 = '0;
                  last2 = '0;
                  shift_in(b);
                  frame_pos = 1;
                  ph = PhStart2;
               end
            end
            PhStart2: begin
               e.byte_kept = 1'b1;
               e.byte_index = 11'd1;
               if (b != StartByte) begin
                  e.frame_last = 1'b1;
                  e.frame_status = StatBadStart;
                  ph = PhHunt;
               end else begin
                  shift_in(b);
                  frame_pos = 2;
                  ph = PhHeader;
               end
            end
            PhHeader: begin
               idx = frame_pos;
               e.byte_kept = 1'b1;
               e.byte_index = idx[10:0];
               if (idx == 2) begin
                  msg_id = b;
               end else if (idx == 3 || idx == 4) begin
                  len_field = {len_field[7:0], b};
               end else begin
                  serial = {serial[23:0], b};
               end
               if (idx >= HdrLast) begin
                  if (FrameOverhead + int'(len_field) > MaxFrame) begin
                     e.frame_last = 1'b1;
                     e.too_long = 1'b1;
                     fill_header(e);
                     ph = PhHunt;
                  end else if (int'(len_field) <= SerialLen) begin
                     close_frame(b, e);
                  end else begin
                     shift_in(b);
                     frame_pos = idx + 1;
                     ph = PhBody;
                  end
               end else begin
                  shift_in(b);
                  frame_pos = idx + 1;
               end
            end
            default: begin
               idx = frame_pos;
               e.byte_kept = 1'b1;
               e.byte_index = idx[10:0];
               if (idx >= SerialLen + int'(len_field)) begin
                  close_frame(b, e);
               end else begin
                  shift_in(b);
                  frame_pos = idx + 1;
               end
            end
         endcase
         if (e.frame_last) begin
            if (e.too_long) oversize++;
            else verdicts[int'(e.frame_status)]++;
         end
         pending_results.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 100)
               $display("%0t: mismatch on %s, expected %0h, actual %0h",
                        $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 100)
               $display("%0t: unexpected result beat, expected none, actual %0h",
                        $time, got);
            return;
         end
         want = pending_results.pop_front();
         if (int'(got.byte_index) > top_index) top_index = int'(got.byte_index);
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("byte_kept", want.byte_kept, got.byte_kept);
         compare_field("byte_index", want.byte_index, got.byte_index);
         compare_field("frame_last", want.frame_last, got.frame_last);
         compare_field("frame_status", want.frame_status, got.frame_status);
         compare_field("too_long", want.too_long, got.too_long);
         compare_field("message_id", want.message_id, got.message_id);
         compare_field("serial_number", want.serial_number, got.serial_number);
         compare_field("length_value", want.length_value, got.length_value);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfd_req_if req_if();
   tfd_rsp_if rsp_if();

   tracker_frame_deframer_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_beat (req_if.sink),
      .rsp_beat (rsp_if.source)
   );

   deframe_scoreboard board = new();

   logic [7:0] wire_bytes[$];
   int         send_idle_pct = 0;
   int         rsp_idle_pct  = 0;
   int         bytes_sent    = 0;
   int         blocked_cycles = 0;
   int         stall_left    = 0;
   bit         stall_request = 1'b0;
   bit         stall_done    = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #3_200_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.data);
         if (req_if.valid && !req_if.ready) blocked_cycles++;
         if (stall_request && !stall_done) begin
            stall_left = 300;
            stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   function automatic void add_frame(logic [7:0] id, logic [15:0] len,
                                     logic [31:0] sn, fault_type fault);
      logic [7:0]  f[$];
      logic [71:0] hdr;
      logic [7:0]  x;
      int          total;
      int          keep;
      hdr = {StartByte, StartByte, id, len, sn};
      for (int i = 0; i <= HdrLast; i++) f.push_back(hdr[71 - 8*i -: 8]);
      total = (int'(len) <= SerialLen) ? HdrLast + 1 : FrameOverhead + int'(len);
      if (total <= MaxFrame) begin
         while (f.size() < total) f.push_back(8'($urandom_range(0, 255)));
         x = '0;
         for (int i = 0; i < total - 2; i++) x = x ^ f[i];
         f[total-2] = x;
         f[total-1] = EndByte;
         if (fault == FaultEnd || fault == FaultBoth)
            f[total-1] = EndByte ^ 8'($urandom_range(1, 255));
         if (fault == FaultSum || fault == FaultBoth)
            f[total-2] = x ^ 8'($urandom_range(1, 255));
      end
      if (fault == FaultCut) begin
         keep = $urandom_range(3, f.size() - 1);
         while (f.size() > keep) void'(f.pop_back());
      end
      foreach (f[i]) wire_bytes.push_back(f[i]);
   endfunction

   function automatic logic [15:0] pick_length();
      if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 120));
      return 16'($urandom_range(0, 24));
   endfunction

   function automatic void queue_random_chunk();
      int         r;
      logic [7:0] b;
      logic [7:0] id;
      logic [31:0] sn;
      r  = $urandom_range(0, 99);
      id = 8'($urandom_range(0, 255));
      sn = $urandom();
      if (r < 50) begin
         add_frame(id, pick_length(), sn, FaultNone);
      end else if (r < 58) begin
         add_frame(id, pick_length(), sn, FaultEnd);
      end else if (r < 66) begin
         add_frame(id, pick_length(), sn, FaultSum);
      end else if (r < 70) begin
         add_frame(id, pick_length(), sn, FaultBoth);
      end else if (r < 76) begin
         b = 8'($urandom_range(0, 255));
         if (b == StartByte) b = ~b;
         wire_bytes.push_back(StartByte);
         wire_bytes.push_back(b);
      end else if (r < 82) begin
         if ($urandom_range(0, 3) == 0) add_frame(id, 16'd2044, sn, FaultNone);
         else add_frame(id, 16'($urandom_range(2044, 65535)), sn, FaultNone);
      end else if (r < 88) begin
         add_frame(id, pick_length(), sn, FaultCut);
      end else begin
         repeat ($urandom_range(1, 4)) wire_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      board.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_queued();
      while (wire_bytes.size() != 0) send_byte(wire_bytes.pop_front());
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct, input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      send_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      while (bytes_sent < stop_at) begin
         queue_random_chunk();
         send_queued();
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fixed cases: noise, bad start, shortest good frame, oversize header
      wire_bytes.push_back(8'h00);
      wire_bytes.push_back(8'hFF);
      wire_bytes.push_back(StartByte);
      wire_bytes.push_back(8'h28);
      add_frame(8'h00, 16'h0000, 32'h0000_0000, FaultNone);
      add_frame(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, FaultNone);
      send_queued();

      run_phase(37, 77, 160);
      run_phase(77, 37, 160);

      // hold the receiver off while bytes keep coming
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      stall_request = 1'b1;
      add_frame(8'h5A, 16'd40, $urandom(), FaultNone);
      send_queued();
      run_phase(0, 0, 160);

      req_if.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes, checked %0d results, top index %0d, %0d stall cycles",
               bytes_sent, board.results_seen, board.top_index, blocked_cycles);
      $display("Frames: %0d good, %0d bad start, %0d bad end, %0d bad sum, %0d oversize",
               board.verdicts[int'(StatGood)], board.verdicts[int'(StatBadStart)],
               board.verdicts[int'(StatBadEnd)], board.verdicts[int'(StatBadSum)],
               board.oversize);
      if (board.errors == 0 && board.pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule : testbench
`default_nettype wire
